// ===== rtl/crsq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsq_pkg: shared types and constants for the column run range query block
// Holds field widths, operation and register codes, the controller state
// type and the command/status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package crsq_pkg;

  localparam int DIM_W   = 9;                   // config / row number width
  localparam int DIM_MAX = (1 << DIM_W) - 1;
  localparam int LROW_W  = DIM_W + 1;           // load row can reach rows+1
  localparam int VAL_W   = 32;
  localparam int RUN_W   = 9;

  localparam int DEF_MAX_ROWS = 256;
  localparam int DEF_MAX_COLS = 256;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // configuration register indexes
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LD_WR,
    S_SCAN,
    S_DRAIN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic cap;       // capture accepted input word
    logic ld_wr;     // write run and previous-row entry, advance position
    logic q_start;   // clear scan column and found flag
    logic q_step;    // read both rows at scan column, advance
    logic res_load;  // load result register
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic ld_skip;   // grid already full
    logic q_bad;     // query range invalid
    logic scan_last; // scan column is the last column in use
    logic out_free;  // result register can take a new word
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/crsq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents undefined at reset.
// ----------------------------------------------------------------------------
module crsq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/crsq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsq_ctrl: sequencer for loads and row range queries
// Accepts one word at a time and steps the datapath through the load
// read/write pair or the column scan, then hands the result over.
// ----------------------------------------------------------------------------
module crsq_ctrl
  import crsq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output      logic in_stall,
  input  wire sts_t sts,
  output      cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        // previous-row memory is read at the load column this cycle
        if (!sts.is_query) begin
          if (sts.ld_skip) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LD_WR;
          end
        end else if (sts.q_bad) begin
          state_nxt = S_RESULT;
        end else begin
          cmd.q_start = 1'b1;
          state_nxt   = S_SCAN;
        end
      end
      S_LD_WR: begin
        cmd.ld_wr = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cmd.q_step = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last compare lands this cycle
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/crsq_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// crsq_dp: datapath of the column run range query block
// Configuration registers, load position, run table (two copies, one per
// queried row), previous-row memory, scan compare and result register.
// ----------------------------------------------------------------------------
module crsq_dp
  import crsq_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [DIM_W-1:0]        cfg_data,
  input  wire logic                    in_op,
  input  wire logic signed [VAL_W-1:0] in_cell_value,
  input  wire logic [DIM_W-1:0]        in_query_low,
  input  wire logic [DIM_W-1:0]        in_query_high,
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      logic                    out_is_sorted,
  output      logic                    out_bad_query,
  input  wire cmd_t                    cmd,
  output      sts_t                    sts
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int SW = (CW > DIM_W) ? CW : DIM_W;
  localparam int RUN_DEPTH  = (1 << RW) * (1 << CW);
  localparam int PREV_DEPTH = 1 << CW;
  localparam logic [DIM_W-1:0] ROWS_CAP = DIM_W'((MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS);
  localparam logic [DIM_W-1:0] COLS_CAP = DIM_W'((MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS);

  logic [DIM_W-1:0]  num_rows_r, num_cols_r;
  logic [DIM_W-1:0]  rows_eff, cols_eff;
  logic [LROW_W-1:0] load_row_r;
  logic [DIM_W-1:0]  load_col_r;

  logic                    op_r;
  logic signed [VAL_W-1:0] val_r;
  logic [DIM_W-1:0]        lo_r, hi_r;

  logic [CW-1:0] scan_col_r;
  logic          cmp_vld_r;
  logic          found_r;

  logic out_valid_r, out_sorted_r, out_bad_r;

  // clamp register values to 1..max
  always_comb begin
    rows_eff = num_rows_r;
    if (num_rows_r == '0) begin
      rows_eff = DIM_W'(1);
    end else if (num_rows_r > ROWS_CAP) begin
      rows_eff = ROWS_CAP;
    end
    cols_eff = num_cols_r;
    if (num_cols_r == '0) begin
      cols_eff = DIM_W'(1);
    end else if (num_cols_r > COLS_CAP) begin
      cols_eff = COLS_CAP;
    end
  end

  // ---------------- load path ----------------
  logic [RW-1:0]              ld_row_idx;
  logic [CW-1:0]              ld_col_idx;
  logic [VAL_W+RUN_W-1:0]     prev_rdata;
  logic signed [VAL_W-1:0]    prev_val;
  logic [RUN_W-1:0]           prev_run;
  logic [RUN_W-1:0]           new_run;
  logic                       col_wrap;

  assign ld_row_idx = RW'(load_row_r - LROW_W'(1));
  assign ld_col_idx = CW'(load_col_r - DIM_W'(1));
  assign prev_val   = prev_rdata[VAL_W+RUN_W-1:RUN_W];
  assign prev_run   = prev_rdata[RUN_W-1:0];
  assign col_wrap   = (load_col_r >= cols_eff);

  always_comb begin
    if (load_row_r == LROW_W'(1)) begin
      new_run = RUN_W'(1);
    end else if (val_r >= prev_val) begin
      new_run = prev_run + RUN_W'(1);
    end else begin
      new_run = RUN_W'(1);
    end
  end

  crsq_ram #(.WIDTH(VAL_W + RUN_W), .DEPTH(PREV_DEPTH)) u_prev_ram (
    .clk   (clk),
    .we    (cmd.ld_wr),
    .waddr (ld_col_idx),
    .wdata ({val_r, new_run}),
    .raddr (ld_col_idx),
    .rdata (prev_rdata)
  );

  // ---------------- query path ----------------
  logic [RW-1:0]    hi_row_idx, lo_row_idx;
  logic [RUN_W-1:0] run_hi, run_lo;
  logic             col_match;

  assign hi_row_idx = RW'(hi_r - DIM_W'(1));
  assign lo_row_idx = RW'(lo_r - DIM_W'(1));

  // both copies take every run write; each serves one queried row
  crsq_ram #(.WIDTH(RUN_W), .DEPTH(RUN_DEPTH)) u_run_hi_ram (
    .clk   (clk),
    .we    (cmd.ld_wr),
    .waddr ({ld_row_idx, ld_col_idx}),
    .wdata (new_run),
    .raddr ({hi_row_idx, scan_col_r}),
    .rdata (run_hi)
  );

  crsq_ram #(.WIDTH(RUN_W), .DEPTH(RUN_DEPTH)) u_run_lo_ram (
    .clk   (clk),
    .we    (cmd.ld_wr),
    .waddr ({ld_row_idx, ld_col_idx}),
    .wdata (new_run),
    .raddr ({lo_row_idx, scan_col_r}),
    .rdata (run_lo)
  );

  assign col_match = (run_hi >= run_lo) && ((run_hi - run_lo) == RUN_W'(hi_r - lo_r));

  // ---------------- status ----------------
  always_comb begin
    sts.is_query  = (op_r == OP_QUERY);
    sts.ld_skip   = (load_row_r > LROW_W'(rows_eff)) || (load_col_r == '0) ||
                    (load_col_r > cols_eff);
    sts.q_bad     = (lo_r == '0) || (lo_r > hi_r) ||
                    (LROW_W'(hi_r) > (load_row_r - LROW_W'(1)));
    sts.scan_last = (SW'(scan_col_r) == SW'(cols_eff - DIM_W'(1)));
    sts.out_free  = !out_valid_r || !out_stall;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r  <= DIM_W'(1);
      num_cols_r  <= DIM_W'(1);
      load_row_r  <= LROW_W'(1);
      load_col_r  <= DIM_W'(1);
      cmp_vld_r   <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_ROWS: num_rows_r <= cfg_data;
          REG_NUM_COLS: num_cols_r <= cfg_data;
          default: ;
        endcase
        load_row_r <= LROW_W'(1);
        load_col_r <= DIM_W'(1);
      end else if (cmd.ld_wr) begin
        if (col_wrap) begin
          load_col_r <= DIM_W'(1);
          load_row_r <= load_row_r + LROW_W'(1);
        end else begin
          load_col_r <= load_col_r + DIM_W'(1);
        end
      end

      cmp_vld_r <= cmd.q_step;
      if (cmd.q_start) begin
        found_r <= 1'b0;
      end else if (cmp_vld_r && col_match) begin
        found_r <= 1'b1;
      end

      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r  <= in_op;
      val_r <= in_cell_value;
      lo_r  <= in_query_low;
      hi_r  <= in_query_high;
    end
    if (cmd.q_start) begin
      scan_col_r <= '0;
    end else if (cmd.q_step) begin
      scan_col_r <= scan_col_r + CW'(1);
    end
    if (cmd.res_load) begin
      out_sorted_r <= found_r && !sts.q_bad;
      out_bad_r    <= sts.q_bad;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_is_sorted = out_sorted_r;
  assign out_bad_query = out_bad_r;

endmodule

`default_nettype wire

// ===== rtl/column_sorted_row_range_query.sv =====
// Load word: capture, previous-row read, then write, after acceptance.
// Query word: one column per cycle through the run table read ports;
//   a rejected range goes from decode straight to the result step.
// Load words give no result; each query gives one result word.
// Reset (rst_n low, synchronous): num_rows = num_cols = 1, loading restarts at
//   row 1 column 1; memories hold no defined contents, no clearing pass.
`default_nettype none
// ----------------------------------------------------------------------------
// column_sorted_row_range_query: non-decreasing column run range query
// Loads a grid of signed values in row-major order, tracking per column the
// length of the non-decreasing run ending at each cell, and answers whether
// any column is non-decreasing over a queried row range.
// ----------------------------------------------------------------------------
module column_sorted_row_range_query
  import crsq_pkg::*;
#(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // configuration write port
  input  wire logic                    cfg_we,
  input  wire logic                    cfg_index,
  input  wire logic [DIM_W-1:0]        cfg_data,
  // input words
  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire logic                    in_op,
  input  wire logic signed [VAL_W-1:0] in_cell_value,
  input  wire logic [DIM_W-1:0]        in_query_low,
  input  wire logic [DIM_W-1:0]        in_query_high,
  // result words
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      logic                    out_is_sorted,
  output      logic                    out_bad_query
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: one input word in flight at a time
  crsq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, scan compare and result register
  crsq_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_op         (in_op),
    .in_cell_value (in_cell_value),
    .in_query_low  (in_query_low),
    .in_query_high (in_query_high),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_is_sorted (out_is_sorted),
    .out_bad_query (out_bad_query),
    .cmd           (cmd),
    .sts           (sts)
  );

  // ---------------- checks ----------------
  // an accepted word blocks the input until its work is done
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a word");

  // result register only reloaded when it is free
  a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> sts.out_free)
    else $error("result register overwritten while stalled");

  // a rejected range never reports a sorted column
  a_bad_not_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_query) |-> !out_is_sorted)
    else $error("bad query reported as sorted");

  // the run table is never written during a column scan
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.q_step |-> !cmd.ld_wr)
    else $error("run table write during scan");

endmodule

`default_nettype wire
